// File: hw/rtl/ccp_pkg.sv
// shared types and constants for the coefficient compress-and-pack block
// no dependencies; imported by every module of the block
`default_nettype none

package ccp_pkg;

	localparam int COEF_W   = 14;
	localparam int MOD_W    = 13;
	localparam int MODE_W   = 2;
	localparam int ACC_W    = 20;
	localparam int PEND_W   = 5;
	localparam int CODE_W   = 13;
	localparam int WIDTH_W  = 4;
	localparam int NUM_W    = 27;
	localparam int QUO_W    = 12;
	localparam int STEP_W   = 5;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [MOD_W-1:0] MODULUS_RESET = 13'd6977;

	// configuration register indexes
	localparam logic REG_MODULUS   = 1'b0;
	localparam logic REG_CODE_MODE = 1'b1;

	// code_mode register values
	localparam logic [MODE_W-1:0] MODE_C5  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_C12 = 2'd1;

	// job kinds after classification
	localparam logic [1:0] KIND_C5  = 2'd0;
	localparam logic [1:0] KIND_C12 = 2'd1;
	localparam logic [1:0] KIND_RAW = 2'd2;

	// code widths and division lengths per kind
	localparam logic [WIDTH_W-1:0] WIDTH_C5  = 4'd5;
	localparam logic [WIDTH_W-1:0] WIDTH_C12 = 4'd12;
	localparam logic [WIDTH_W-1:0] WIDTH_RAW = 4'd13;
	localparam logic [STEP_W-1:0]  STEPS_C5  = 5'd20;
	localparam logic [STEP_W-1:0]  STEPS_C12 = 5'd27;

	typedef struct packed {
		logic [MOD_W-1:0]  modulus;
		logic [MODE_W-1:0] code_mode;
	} cfg_t;

	typedef struct packed {
		logic [COEF_W-1:0] x;
		logic [1:0]        kind;
		logic              last;
	} job_t;

endpackage

`default_nettype wire

// File: hw/rtl/ccp_front.sv
// front end: accepts coefficients, applies the negative correction, classifies by mode
// depends on ccp_pkg
`default_nettype none

module ccp_front
	import ccp_pkg::*;
(
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [COEF_W-1:0] coefficient,
	input  wire logic              final_coefficient,
	input  wire logic              q_full,
	output logic                   q_push,
	output job_t                   q_job
);

	logic [COEF_W-1:0] corrected;

	// wraps to 14 bits when the sum stays negative
	assign corrected = coefficient[COEF_W-1]
		? coefficient + {1'b0, cfg.modulus}
		: coefficient;

	always_comb begin
		q_job.x    = corrected;
		q_job.last = final_coefficient;
		unique case (cfg.code_mode)
			MODE_C5:  q_job.kind = KIND_C5;
			MODE_C12: q_job.kind = KIND_C12;
			default:  q_job.kind = KIND_RAW;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

// File: hw/rtl/ccp_queue.sv
// short job queue between the front end and the divide-and-pack back end
// depends on ccp_pkg
`default_nettype none

module ccp_queue
	import ccp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output job_t      head
);

	job_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ccp_back.sv
// back end: bit-serial rounding division, bit accumulator and byte output register
// depends on ccp_pkg
`default_nettype none

module ccp_back
	import ccp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic q_empty,
	input  wire job_t q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] packed_byte,
	output logic      end_of_stream
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DIV   = 2'd1;
	localparam logic [1:0] S_MERGE = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         kind_q;
	logic               last_q;
	logic [NUM_W-1:0]   num_q;
	logic [MOD_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [STEP_W-1:0]  step_q;
	logic [CODE_W-1:0]  code_q;
	logic [WIDTH_W-1:0] width_q;
	logic [ACC_W-1:0]   acc_q;
	logic [PEND_W-1:0]  pend_q;
	logic               out_valid_q;
	logic [7:0]         byte_q;
	logic               eos_q;

	logic [19:0]        num_c5;
	logic [NUM_W-1:0]   num_c12;
	logic [MOD_W:0]     rem_shift;
	logic               rem_ge;
	logic [QUO_W-1:0]   quo_next;
	logic               out_free;
	logic               full_byte;
	logic               out_load;
	logic               out_load_eos;

	assign num_c5  = {1'b0, q_head.x, 5'b0} + 20'(cfg.modulus[MOD_W-1:1]);
	assign num_c12 = {1'b0, q_head.x, 12'b0} + NUM_W'(cfg.modulus[MOD_W-1:1]);

	// one restoring step: bring down the next numerator bit
	assign rem_shift = {rem_q, num_q[NUM_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, cfg.modulus});
	assign quo_next  = {quo_q[QUO_W-2:0], rem_ge};

	assign out_free     = !out_valid_q || !out_stall;
	assign full_byte    = (pend_q >= PEND_W'(8));
	assign out_load     = (state_q == S_EMIT) && out_free
		&& (full_byte || (last_q && pend_q != '0));
	assign out_load_eos = last_q && (pend_q <= PEND_W'(8));

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q  <= q_head.kind;
			last_q  <= q_head.last;
			num_q   <= (q_head.kind == KIND_C5) ? {num_c5, 7'b0} : num_c12;
			rem_q   <= '0;
			quo_q   <= '0;
			step_q  <= (q_head.kind == KIND_C5) ? STEPS_C5 : STEPS_C12;
			code_q  <= q_head.x[CODE_W-1:0];
			unique case (q_head.kind)
				KIND_C5:  width_q <= WIDTH_C5;
				KIND_C12: width_q <= WIDTH_C12;
				default:  width_q <= WIDTH_RAW;
			endcase
		end else if (state_q == S_DIV) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= rem_ge ? MOD_W'(rem_shift - {1'b0, cfg.modulus})
				: rem_shift[MOD_W-1:0];
			quo_q  <= quo_next;
			step_q <= step_q - 1'b1;
			if (kind_q == KIND_C5) begin
				code_q <= CODE_W'(quo_next[4:0]);
			end else begin
				code_q <= CODE_W'(quo_next);
			end
		end
		if (out_load) begin
			byte_q <= acc_q[7:0];
			eos_q  <= out_load_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= (q_head.kind == KIND_RAW) ? S_MERGE : S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == STEP_W'(1)) begin
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					acc_q   <= acc_q | (ACC_W'(code_q) << pend_q[2:0]);
					pend_q  <= pend_q + PEND_W'(width_q);
					state_q <= S_EMIT;
				end
				default: begin
					priority if (full_byte) begin
						if (out_free) begin
							acc_q  <= acc_q >> 8;
							pend_q <= pend_q - PEND_W'(8);
						end
					end else if (last_q) begin
						// flush the partial byte, then empty the accumulator
						if (out_free || pend_q == '0) begin
							acc_q   <= '0;
							pend_q  <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign packed_byte   = byte_q;
	assign end_of_stream = eos_q;

	a_idle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pend_q < PEND_W'(8)))
		else $error("pending bits not below a byte between items");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(ACC_W))
		else $error("pending bits exceed accumulator");

	a_eos_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_load_eos) |=> (pend_q == '0))
		else $error("accumulator not empty after end of stream byte");

	a_pop_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_DIV || state_q == S_MERGE))
		else $error("job popped without starting work");

endmodule

`default_nettype wire

// File: hw/rtl/coefficient_compress_pack.sv
// top level of the coefficient compress-and-pack block: config registers and wiring
// depends on ccp_pkg, ccp_front, ccp_queue, ccp_back
`default_nettype none

// Takes one signed coefficient per item, adds the modulus when it is negative,
// then compresses it to 5 or 12 bits as round(x*2^d/q) mod 2^d or keeps 13 raw
// bits, and streams the codes out as bytes, least significant bit first. The
// item marked final flushes a zero-padded partial byte and tags the last byte
// with end_of_stream. The rounding division runs bit-serially, one numerator
// bit per cycle, over 20 numerator bits for a 5-bit item and 27 for a 12-bit
// item, while a raw item skips the division; the back end then sends each full
// byte, holding while the output is stalled, and the flush of a partial byte
// shares its cycle with the return to idle. A two-entry queue lets the
// input run ahead of the divider by two items. modulus and code_mode may only
// be written while the block holds no unfinished item.
module coefficient_compress_pack
	import ccp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [MOD_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [COEF_W-1:0] coefficient,
	input  wire logic              final_coefficient,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             packed_byte,
	output logic                   end_of_stream
);

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus   <= MODULUS_RESET;
			cfg_q.code_mode <= MODE_C5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:   cfg_q.modulus   <= cfg_data;
				REG_CODE_MODE: cfg_q.code_mode <= cfg_data[MODE_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	ccp_front u_front (
		.cfg               (cfg_q),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.coefficient       (coefficient),
		.final_coefficient (final_coefficient),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_job             (push_job)
	);

	ccp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	ccp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_head        (head_job),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.packed_byte   (packed_byte),
		.end_of_stream (end_of_stream)
	);

endmodule

`default_nettype wire

// File: tb/sv/coefficient_pack_checker.sv
// checker for the coefficient compress-and-pack block: follows the register writes,
// predicts the packed byte stream of every accepted item and compares it on the output
// depends on ccp_pkg
`default_nettype none

module coefficient_pack_checker
	import ccp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [MOD_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [COEF_W-1:0] coefficient,
	input  wire logic              final_coefficient,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [7:0]        packed_byte,
	input  wire logic              end_of_stream,
	output int                     errors,
	output int                     expected_left,
	output int                     bytes_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} stream_byte_t;

	stream_byte_t      expected_bytes [$];
	logic [MOD_W-1:0]  modulus_q;
	logic [MODE_W-1:0] mode_q;
	logic [ACC_W-1:0]  acc;
	int                pend;
	int                err_count = 0;
	int                left_count = 0;
	int                checked_count = 0;

	assign errors        = err_count;
	assign expected_left = left_count;
	assign bytes_checked = checked_count;

	// round(x * 2^d / q) mod 2^d, all ones when q is zero
	function automatic logic [CODE_W-1:0] compressed_code(input logic [COEF_W-1:0] x,
			input logic [MOD_W-1:0] q, input int d);
		logic [31:0] mask;
		logic [31:0] num;
		logic [31:0] quo;
		mask = (32'd1 << d) - 32'd1;
		if (q == '0) begin
			quo = mask;
		end else begin
			num = ({18'b0, x} << d) + {19'b0, q >> 1};
			quo = num / {19'b0, q};
		end
		quo = quo & mask;
		return quo[CODE_W-1:0];
	endfunction

	task automatic pack_coefficient(input logic [COEF_W-1:0] coef_bits, input logic is_final);
		int               value;
		logic [COEF_W-1:0] x;
		logic [CODE_W-1:0] code;
		int               width;
		logic [31:0]      merged;
		logic [7:0]       staged [0:3];
		logic             staged_eos [0:3];
		int               n;
		int               k;
		stream_byte_t     entry;
		value = int'($signed(coef_bits));
		if (value < 0)
			value = value + int'(modulus_q);
		// a sum that is still negative wraps to 14 bits
		x = value[COEF_W-1:0];
		case (mode_q)
			MODE_C5: begin
				code  = compressed_code(x, modulus_q, 5);
				width = 5;
			end
			MODE_C12: begin
				code  = compressed_code(x, modulus_q, 12);
				width = 12;
			end
			default: begin
				code  = x[CODE_W-1:0];
				width = 13;
			end
		endcase
		merged = ({12'b0, acc} | ({19'b0, code} << pend)) & 32'hFFFFF;
		acc    = merged[ACC_W-1:0];
		pend   = pend + width;
		n      = 0;
		while (pend >= 8) begin
			staged[n]     = acc[7:0];
			staged_eos[n] = 1'b0;
			n    = n + 1;
			acc  = acc >> 8;
			pend = pend - 8;
		end
		if (is_final) begin
			if (pend > 0) begin
				staged[n]     = acc[7:0];
				staged_eos[n] = 1'b1;
				n = n + 1;
			end else if (n > 0) begin
				staged_eos[n-1] = 1'b1;
			end
			acc  = '0;
			pend = 0;
		end
		for (k = 0; k < n; k++) begin
			entry.data = staged[k];
			entry.eos  = staged_eos[k];
			expected_bytes.push_back(entry);
		end
	endtask

	task automatic check_byte();
		stream_byte_t want;
		if (expected_bytes.size() == 0) begin
			err_count = err_count + 1;
			if (err_count <= 10)
				$display("unexpected byte %02h eos %0b with nothing pending", packed_byte,
					end_of_stream);
		end else begin
			want = expected_bytes.pop_front();
			checked_count = checked_count + 1;
			if (packed_byte !== want.data || end_of_stream !== want.eos) begin
				err_count = err_count + 1;
				if (err_count <= 10)
					$display("byte %0d: expected %02h eos %0b, got %02h eos %0b",
						checked_count, want.data, want.eos, packed_byte, end_of_stream);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q = MODULUS_RESET;
			mode_q    = MODE_C5;
			acc       = '0;
			pend      = 0;
			expected_bytes.delete();
			left_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MODULUS)
					modulus_q = cfg_data;
				else
					mode_q = cfg_data[MODE_W-1:0];
			end
			if (in_valid && !in_stall)
				pack_coefficient(coefficient, final_coefficient);
			if (out_valid && !out_stall)
				check_byte();
			left_count = expected_bytes.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_coefficient_compress_pack.sv
// testbench top for the coefficient compress-and-pack block: clock, reset, register
// writes, coefficient stimulus with random gaps and output stalls, verdict
// depends on ccp_pkg, coefficient_compress_pack and coefficient_pack_checker
`default_nettype none

module tb_coefficient_compress_pack;
	import ccp_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RAW     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RAW_ALT = 2'd3;
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_ITEMS   = 46;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [MOD_W-1:0]  cfg_data;
	logic              in_valid;
	logic [COEF_W-1:0] coefficient;
	logic              final_coefficient;
	logic              out_stall = 1'b0;
	wire logic         in_stall;
	wire logic         out_valid;
	wire logic [7:0]   packed_byte;
	wire logic         end_of_stream;
	int                errors;
	int                expected_left;
	int                bytes_checked;

	logic [MOD_W-1:0]  cur_modulus = MODULUS_RESET;
	int                items_sent = 0;
	int                settings_used = 1;
	int                burst_left = 0;
	int                stall_left = 0;
	int                calm_left = 0;
	int                stall_roll;

	coefficient_compress_pack DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coefficient(coefficient),
		.final_coefficient(final_coefficient),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packed_byte(packed_byte),
		.end_of_stream(end_of_stream)
	);

	coefficient_pack_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coefficient(coefficient),
		.final_coefficient(final_coefficient),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packed_byte(packed_byte),
		.end_of_stream(end_of_stream),
		.errors(errors),
		.expected_left(expected_left),
		.bytes_checked(bytes_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: short random stalls, a few long ones, and calm stretches
	always @(posedge clk) begin
		if (calm_left > 0) begin
			out_stall <= 1'b0;
			calm_left = calm_left - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 3)
				calm_left = $urandom_range(30, 150);
			else if (stall_roll < 6)
				stall_left = $urandom_range(10, 40);
			else
				out_stall <= (stall_roll < 30);
		end
	end

	task automatic pause_sender();
		int roll;
		int gap;
		gap = 0;
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				burst_left = $urandom_range(20, 60);
			else if (roll < 55)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(1, 3);
			else if (roll < 95)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_coefficient(input int value, input logic is_final);
		logic [31:0] bits;
		bits = value;
		in_valid          <= 1'b1;
		coefficient       <= bits[COEF_W-1:0];
		final_coefficient <= is_final;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent = items_sent + 1;
		pause_sender();
	endtask

	// hold the input until every predicted byte is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
	endtask

	task automatic write_settings(input logic [MOD_W-1:0] q, input logic [MODE_W-1:0] mode);
		drain();
		// items that make no byte may still be in the divider
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODULUS;
		cfg_data  <= q;
		@(posedge clk);
		cfg_index <= REG_CODE_MODE;
		cfg_data  <= {{(MOD_W-MODE_W){1'b0}}, mode};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_modulus   = q;
		settings_used = settings_used + 1;
	endtask

	function automatic int random_coefficient();
		int q;
		int roll;
		q    = int'(cur_modulus);
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			case ($urandom_range(0, 5))
				0: return 8191;
				1: return -8191;
				2: return -8192;
				3: return 0;
				4: return q;
				default: return -q;
			endcase
		end
		if (roll < 20 || q == 0)
			return int'($urandom_range(0, 16383)) - 8192;
		// well-formed: strictly between minus q and q
		return int'($urandom_range(0, 2 * q - 2)) - (q - 1);
	endfunction

	task automatic run_polynomials(input int count);
		int left;
		int len;
		int k;
		logic fin;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(17, 60);
			else
				len = $urandom_range(1, 16);
			for (k = 0; k < len && left > 0; k++) begin
				fin = (k == len - 1) || ($urandom_range(0, 49) == 0);
				send_coefficient(random_coefficient(), fin);
				left = left - 1;
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end
	endtask

	initial begin
		int p;
		logic [MOD_W-1:0] q;
		logic [MODE_W-1:0] m;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_MODULUS;
		cfg_data          = '0;
		in_valid          = 1'b0;
		coefficient       = '0;
		final_coefficient = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, 5-bit codes: extremes, rounding edges, final on a byte boundary
		send_coefficient(0, 1'b0);
		send_coefficient(8191, 1'b0);
		send_coefficient(-8191, 1'b0);
		send_coefficient(-8192, 1'b0);
		send_coefficient(-1, 1'b0);
		send_coefficient(3488, 1'b0);
		send_coefficient(3489, 1'b0);
		send_coefficient(6976, 1'b1);
		// final with a partial byte only
		send_coefficient(17, 1'b1);

		write_settings(13'd6977, MODE_C12);
		send_coefficient(0, 1'b0);
		send_coefficient(6976, 1'b0);
		send_coefficient(-3489, 1'b0);
		send_coefficient(8191, 1'b1);
		send_coefficient(-6977, 1'b1);

		write_settings(13'd8191, MODE_RAW);
		send_coefficient(8191, 1'b0);
		send_coefficient(-8192, 1'b0);
		send_coefficient(0, 1'b0);
		send_coefficient(-1, 1'b1);

		// tiny modulus leaves the sum negative; code mode three packs raw
		write_settings(13'd5, MODE_RAW_ALT);
		send_coefficient(-8191, 1'b0);
		send_coefficient(4, 1'b0);
		send_coefficient(-3, 1'b1);

		// modulus zero: no correction, compressed codes saturate
		write_settings(13'd0, MODE_C5);
		send_coefficient(-5, 1'b0);
		send_coefficient(100, 1'b1);
		write_settings(13'd0, MODE_C12);
		send_coefficient(-1, 1'b1);
		write_settings(13'd0, MODE_RAW);
		send_coefficient(-8191, 1'b0);
		send_coefficient(17, 1'b1);

		for (p = 0; p < 9; p++) begin
			case (p)
				0: begin q = 13'd3329; m = MODE_C5;  end
				1: begin q = 13'd3329; m = MODE_C12; end
				2: begin q = 13'd2;    m = MODE_C5;  end
				3: begin q = 13'd8191; m = MODE_C12; end
				4: begin q = 13'd7681; m = MODE_RAW; end
				5: begin q = 13'd1;    m = MODE_C12; end
				6: begin q = 13'd0;    m = MODE_C5;  end
				7: begin q = MOD_W'($urandom_range(2, 8191)); m = MODE_RAW_ALT; end
				default: begin
					q = MOD_W'($urandom_range(2, 8191));
					m = MODE_W'($urandom_range(0, 3));
				end
			endcase
			write_settings(q, m);
			run_polynomials(PHASE_ITEMS);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d coefficients over %0d register settings (all code modes,",
			items_sent, settings_used);
		$display("modulus 0 to 8191), %0d packed bytes compared", bytes_checked);
		if (errors == 0 && expected_left == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_front.sv
hw/rtl/ccp_queue.sv
hw/rtl/ccp_back.sv
hw/rtl/coefficient_compress_pack.sv
tb/sv/coefficient_pack_checker.sv
tb/sv/tb_coefficient_compress_pack.sv
